@@ hdl/scc_pkg.sv @@
// shared types, constants and state update functions of the serial controller
// depends on nothing; imported by scc_fifo and the top level
`default_nettype none

package scc_pkg;

  localparam int FIFO_DEPTH = 4096;
  localparam int ADDR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FIFO_DEPTH);
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

  // item modes
  localparam logic [2:0] MODE_WRITE = 3'd0;
  localparam logic [2:0] MODE_READ = 3'd1;
  localparam logic [2:0] MODE_PUSH = 3'd2;
  localparam logic [2:0] MODE_POP = 3'd3;
  localparam logic [2:0] MODE_CONNECT = 3'd4;
  localparam logic [2:0] MODE_WRITABLE = 3'd5;
  localparam logic [2:0] MODE_ACK = 3'd6;

  // bus ports
  localparam logic [2:0] PORT_B_CTRL = 3'd1;
  localparam logic [2:0] PORT_B_DATA = 3'd3;
  localparam logic [2:0] PORT_A_CTRL = 3'd5;
  localparam logic [2:0] PORT_A_DATA = 3'd7;

  // register indexes
  localparam logic [3:0] REG_CMD = 4'd0;
  localparam logic [3:0] REG_INT = 4'd1;
  localparam logic [3:0] REG_VEC = 4'd2;
  localparam logic [3:0] REG_RX = 4'd3;
  localparam logic [3:0] REG_MISC = 4'd5;
  localparam logic [3:0] REG_TXDATA = 4'd8;
  localparam logic [3:0] REG_MIC = 4'd9;

  // write register 0 commands
  localparam logic [2:0] CMD_NULL = 3'd0;
  localparam logic [2:0] CMD_POINT_HIGH = 3'd1;
  localparam logic [2:0] CMD_ARM_RX = 3'd4;
  localparam logic [2:0] CMD_RESET_TX = 3'd5;

  // interrupt causes
  localparam logic [1:0] CAUSE_NONE = 2'd0;
  localparam logic [1:0] CAUSE_RX = 2'd1;
  localparam logic [1:0] CAUSE_TX = 2'd2;
  localparam logic [1:0] CAUSE_MOUSE = 2'd3;

  // request handlers
  localparam logic [1:0] HND_NONE = 2'd0;
  localparam logic [1:0] HND_SERIAL = 2'd1;
  localparam logic [1:0] HND_MOUSE = 2'd2;

  typedef struct packed {
    logic [2:0]        mode;
    logic [3:0]        bus_address;
    logic [7:0]        write_data;
    logic              flag_value;
    logic signed [7:0] mouse_dx;
    logic signed [7:0] mouse_dy;
    logic [7:0]        mouse_buttons;
  } scc_in_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        rx_accepted;
    logic [7:0]  tx_byte;
    logic        tx_valid;
    logic [7:0]  ack_vector;
    logic        ack_valid;
    logic        irq_request;
    logic [1:0]  irq_source;
    logic [12:0] tx_fill;
  } scc_out_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic clr;
  } scc_fifo_cmd_t;

  typedef struct packed {
    logic [15:0][7:0] ra;
    logic [15:0][7:0] rb;
    logic [3:0]       ptr_a;
    logic             ptr_a_set;
    logic [3:0]       ptr_b;
    logic             ptr_b_set;
    logic [7:0]       vbase;
    logic [1:0]       mouse_left;
    logic             mouse_acked;
    logic [CNT_W-1:0] rx_cnt;
    logic [CNT_W-1:0] tx_cnt;
    logic             first_pending;
    logic             armed;
    logic             tx_pending;
    logic             connected;
    logic             writable;
    logic [1:0]       cur;
    logic [1:0]       last;
    logic [1:0]       rr;
    logic [1:0]       handler;
    scc_fifo_cmd_t    rx_cmd;
    scc_fifo_cmd_t    tx_cmd;
    logic             pkt_load;
  } scc_state_t;

  function automatic logic rx_int_pending(scc_state_t s);
    logic [1:0] m;
    m = s.ra[REG_INT][4:3];
    if (m == 2'b01) return s.first_pending;
    if (m == 2'b10) return s.rx_cnt != '0;
    return 1'b0;
  endfunction

  function automatic logic mouse_pending(scc_state_t s);
    logic [1:0] m;
    m = s.rb[REG_INT][4:3];
    return !s.mouse_acked && ((s.mouse_left != 2'd0 && m == 2'b10) ||
                              (s.mouse_left == 2'd3 && m == 2'b01));
  endfunction

  function automatic logic cause_pending(scc_state_t s, logic [1:0] c);
    logic r;
    case (c)
      CAUSE_RX: r = rx_int_pending(s);
      CAUSE_TX: r = s.tx_pending && s.ra[REG_INT][1] && s.connected && s.writable &&
                    s.tx_cnt < CNT_FULL;
      CAUSE_MOUSE: r = mouse_pending(s);
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] vector_for(scc_state_t s, logic [1:0] c);
    logic [7:0] b;
    if (s.rb[REG_MIC][4]) begin
      b = s.vbase & 8'h8f;
      if (c == CAUSE_RX) return b + 8'h30;
      if (c == CAUSE_TX) return b + 8'h10;
      return b + 8'h20;
    end
    b = s.vbase & 8'hf1;
    if (c == CAUSE_RX) return b + 8'd12;
    if (c == CAUSE_TX) return b + 8'd8;
    return b + 8'd4;
  endfunction

  function automatic logic [7:0] null_vector(scc_state_t s);
    if (s.rb[REG_MIC][4]) return (s.vbase & 8'h8f) + 8'h60;
    return (s.vbase & 8'hf1) + 8'd6;
  endfunction

  // three-way round robin search used by the vector read
  function automatic logic [1:0] pick3(scc_state_t s);
    logic [1:0] k;
    k = (s.rr == CAUSE_RX) ? CAUSE_TX : (s.rr == CAUSE_TX) ? CAUSE_MOUSE : CAUSE_RX;
    for (int i = 0; i < 3; i++) begin
      if (cause_pending(s, k)) return k;
      k = (k == CAUSE_MOUSE) ? CAUSE_RX : k + 2'd1;
    end
    return CAUSE_NONE;
  endfunction

  function automatic scc_state_t serial_check(scc_state_t s);
    logic [1:0] c0;
    logic [1:0] c1;
    if (!s.rb[REG_MIC][3]) return s;
    if (s.cur != CAUSE_NONE) begin
      if (cause_pending(s, s.cur)) return s;
      s.cur = CAUSE_NONE;
    end
    c0 = s.rr[0] ? CAUSE_TX : CAUSE_RX;
    c1 = s.rr[0] ? CAUSE_RX : CAUSE_TX;
    if (cause_pending(s, c0)) begin
      s.cur = c0;
      s.handler = HND_SERIAL;
    end else if (cause_pending(s, c1)) begin
      s.cur = c1;
      s.handler = HND_SERIAL;
    end else begin
      s.handler = HND_NONE;
    end
    return s;
  endfunction

  function automatic scc_state_t int_check(scc_state_t s);
    if (!s.rb[REG_MIC][3]) return s;
    if (mouse_pending(s)) begin
      s.cur = CAUSE_NONE;
      s.handler = HND_MOUSE;
      return s;
    end
    return serial_check(s);
  endfunction

  function automatic scc_state_t host_reset(scc_state_t s);
    s.rx_cnt = '0;
    s.tx_cnt = '0;
    s.rx_cmd.clr = 1'b1;
    s.tx_cmd.clr = 1'b1;
    s.first_pending = 1'b0;
    s.armed = 1'b0;
    s.tx_pending = s.connected && s.writable && s.ra[REG_INT][1];
    if (s.cur == CAUSE_RX || s.cur == CAUSE_TX) s.cur = CAUSE_NONE;
    return int_check(s);
  endfunction

  function automatic scc_state_t guest_tx_write(scc_state_t s);
    if (!s.connected) begin
      s.tx_pending = 1'b0;
      return s;
    end
    if (s.tx_cnt >= CNT_FULL) return s;
    s.tx_cmd.push = 1'b1;
    s.tx_cnt = s.tx_cnt + CNT_ONE;
    if (s.writable && s.ra[REG_INT][1] && s.tx_cnt < CNT_FULL) s.tx_pending = 1'b1;
    return int_check(s);
  endfunction

  function automatic scc_state_t rx_read(scc_state_t s);
    if (s.rx_cnt == '0) return s;
    s.rx_cmd.pop = 1'b1;
    s.rx_cnt = s.rx_cnt - CNT_ONE;
    s.first_pending = 1'b0;
    return int_check(s);
  endfunction

  function automatic scc_state_t write_wr9(scc_state_t s, logic [7:0] d, logic chan_a);
    if (chan_a && d[7]) begin
      s.ra = '0;
      s.ra[REG_VEC] = s.vbase;
      s = host_reset(s);
    end
    if (chan_a) begin
      s.ra[REG_MIC] = d & 8'h3f;
      s.rb[REG_MIC] = d & 8'h3f;
    end else begin
      s.rb[REG_MIC] = d;
    end
    if (!d[3]) begin
      if (s.cur != CAUSE_NONE) begin
        s.cur = CAUSE_NONE;
        s.handler = HND_NONE;
      end
      return s;
    end
    if (s.connected) s = int_check(s);
    return s;
  endfunction

  function automatic scc_state_t write_reg_a(scc_state_t s, logic [3:0] r, logic [7:0] d);
    logic [7:0] old;
    old = s.ra[REG_INT];
    if (r == REG_VEC) begin
      s.rb[REG_VEC] = d;
      s.vbase = d;
    end else if (r == REG_MIC) begin
      return write_wr9(s, d, 1'b1);
    end
    if (r == REG_INT) begin
      if (d[4:3] == 2'b01 && old[4:3] != 2'b01) begin
        s.armed = 1'b1;
        if (s.rx_cnt != '0) begin
          s.first_pending = 1'b1;
          s.armed = 1'b0;
        end
      end
      if (d[4:3] == 2'b00) begin
        s.armed = 1'b0;
        s.first_pending = 1'b0;
      end
      if (s.connected && d[1] && !old[1] && s.writable && s.tx_cnt < CNT_FULL)
        s.tx_pending = 1'b1;
      if (!d[1]) s.tx_pending = 1'b0;
    end
    s.ra[r] = d;
    if (r == REG_TXDATA) s = guest_tx_write(s);
    if (s.connected) s = int_check(s);
    return s;
  endfunction

  function automatic scc_state_t write_command_a(scc_state_t s, logic [7:0] d);
    logic [2:0] cmd;
    cmd = d[5:3];
    s.ptr_a = {1'b0, d[2:0]};
    s.ptr_a_set = d[2:0] != 3'd0;
    if (cmd == CMD_NULL) return s;
    if (cmd == CMD_POINT_HIGH) begin
      s.ptr_a = {1'b1, d[2:0]};
      s.ptr_a_set = 1'b1;
      return s;
    end
    if (cmd == CMD_ARM_RX) begin
      s.armed = 1'b1;
      if (s.rx_cnt != '0) begin
        s.first_pending = 1'b1;
        s.armed = 1'b0;
      end
    end else if (cmd == CMD_RESET_TX) begin
      s.tx_pending = 1'b0;
    end
    return int_check(s);
  endfunction

endpackage

`default_nettype wire

@@ hdl/scc_serial_mouse_register_device_unit.sv @@
// top level of the two-channel serial controller with mouse packet latch
// depends on scc_pkg and scc_fifo (receive and transmit byte fifos)
`default_nettype none

//  channel  | ports                      | transfer carries
//  ---------+----------------------------+------------------------------------
//  in       | in_valid in_stall in_data  | bus access, host byte or host event
//  out      | out_valid out_stall out_data | one result per input transfer
//
//  one item per cycle sustained while out_stall is low; an item passes the input
//  register, then the result register, from which its result transfers
//  all work for an item is one pass of logic between the two registers; the
//  fifo head byte is prefetched from the ram so it is ready in that pass
//  synchronous active-low reset clears every control register and empties fifos
//  a stalled result holds; the input register still takes one more transfer

module scc_serial_mouse_register_device_unit
  import scc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire scc_in_t  in_data,
  output logic          out_valid,
  input  wire logic     out_stall,
  output scc_out_t      out_data
);

  scc_in_t    in_r;
  logic       in_vld_r;
  scc_out_t   out_r, out_nxt;
  logic       out_vld_r;
  scc_state_t state_r, s;
  logic [7:0] pkt_r [3];
  logic [7:0] rx_head, tx_head;
  logic       out_rdy, proc;

  // per-item scratch
  logic [7:0] d;
  logic [2:0] port;
  logic [3:0] p;
  logic [1:0] c;
  logic [7:0] r9;
  logic       pop_from_full, nflag;

  assign out_rdy = !out_vld_r || !out_stall;
  assign proc = in_vld_r && out_rdy;
  assign in_stall = in_vld_r && !out_rdy;
  assign out_valid = out_vld_r;
  assign out_data = out_r;

  // item evaluation: follows the register semantics step by step
  always_comb begin
    s = state_r;
    s.rx_cmd = '0;
    s.tx_cmd = '0;
    s.pkt_load = 1'b0;
    out_nxt = '0;
    d = in_r.write_data;
    port = in_r.bus_address[2:0];
    p = '0;
    c = CAUSE_NONE;
    r9 = s.rb[REG_MIC];
    pop_from_full = 1'b0;
    nflag = 1'b0;

    case (in_r.mode)
      MODE_WRITE: begin
        if (!in_r.bus_address[3]) begin
          case (port)
            PORT_B_CTRL: begin
              if (s.ptr_b_set) begin
                p = s.ptr_b;
                if (p == REG_MIC) begin
                  s = write_wr9(s, d, 1'b0);
                end else begin
                  // mouse packet latches on a rising wr5 bit 1 while wr3 bit 0 is set and no packet bytes are left
                  if (p == REG_MISC) begin
                    if (!s.rb[REG_MISC][1] && d[1] && s.rb[REG_RX][0] &&
                        s.mouse_left == 2'd0) begin
                      s.mouse_left = 2'd3;
                      s.mouse_acked = 1'b0;
                      s.pkt_load = 1'b1;
                    end
                  end else if (p == REG_VEC) begin
                    s.vbase = d;
                  end
                  s.rb[p] = d;
                end
                s.ptr_b_set = 1'b0;
                s.ptr_b = '0;
              end else if (d[7:4] == 4'd0) begin
                s.ptr_b_set = 1'b1;
                s.ptr_b = d[3:0];
              end else begin
                s.ptr_b_set = 1'b0;
                s.ptr_b = '0;
              end
            end
            PORT_A_CTRL: begin
              if (s.ptr_a_set) begin
                p = s.ptr_a;
                s.ptr_a_set = 1'b0;
                s = write_reg_a(s, p, d);
                s.ptr_a = '0;
              end else begin
                s = write_command_a(s, d);
              end
            end
            PORT_A_DATA: s = guest_tx_write(s);
            default: ;
          endcase
        end
      end
      MODE_READ: begin
        if (!in_r.bus_address[3]) begin
          case (port)
            PORT_B_CTRL: begin
              if (s.connected && s.ptr_b == REG_VEC) begin
                // status-dependent vector readout
                c = s.last;
                if (c == CAUSE_NONE) begin
                  c = s.cur;
                  if (c == CAUSE_NONE || !cause_pending(s, c)) c = pick3(s);
                end
                out_nxt.read_data = (c == CAUSE_NONE) ? null_vector(s) : vector_for(s, c);
                s.last = CAUSE_NONE;
              end else if (s.ptr_b == REG_CMD) begin
                out_nxt.read_data = {7'd0, s.mouse_left != 2'd0};
              end
              s.ptr_b = '0;
              s.ptr_b_set = 1'b0;
            end
            PORT_B_DATA: begin
              if (s.mouse_left != 2'd0) begin
                s.mouse_acked = 1'b0;
                s.mouse_left = s.mouse_left - 2'd1;
                out_nxt.read_data = (s.mouse_left == 2'd2) ? pkt_r[2] :
                                    (s.mouse_left == 2'd1) ? pkt_r[1] : pkt_r[0];
              end
            end
            PORT_A_CTRL: begin
              p = s.ptr_a;
              case (p)
                REG_CMD: out_nxt.read_data = {2'b00, s.connected, 1'b0, s.connected,
                  !s.connected || (s.writable && s.tx_cnt < CNT_FULL), 1'b0,
                  s.rx_cnt != '0};
                REG_INT: out_nxt.read_data = {7'd0,
                  s.connected && s.writable && s.tx_cnt == '0};
                REG_VEC: out_nxt.read_data = s.connected ? s.vbase : 8'd0;
                REG_RX: out_nxt.read_data = {2'b00, s.connected && rx_int_pending(s),
                  s.connected && cause_pending(s, CAUSE_TX), 1'b0,
                  s.mouse_left != 2'd0, 2'b00};
                REG_TXDATA: begin
                  if (s.rx_cnt != '0) out_nxt.read_data = rx_head;
                  s = rx_read(s);
                end
                default: out_nxt.read_data = s.connected ? s.ra[p] : 8'd0;
              endcase
              s.ptr_a = '0;
              s.ptr_a_set = 1'b0;
            end
            PORT_A_DATA: begin
              if (s.rx_cnt != '0) out_nxt.read_data = rx_head;
              s = rx_read(s);
            end
            default: ;
          endcase
        end
      end
      MODE_PUSH: begin
        if (s.connected && s.rx_cnt < CNT_FULL) begin
          if (s.armed) begin
            s.first_pending = 1'b1;
            s.armed = 1'b0;
          end
          s.rx_cmd.push = 1'b1;
          s.rx_cnt = s.rx_cnt + CNT_ONE;
          out_nxt.rx_accepted = 1'b1;
          s = int_check(s);
        end
      end
      MODE_POP: begin
        if (s.connected && s.tx_cnt != '0) begin
          pop_from_full = s.tx_cnt == CNT_FULL;
          out_nxt.tx_byte = tx_head;
          out_nxt.tx_valid = 1'b1;
          s.tx_cmd.pop = 1'b1;
          s.tx_cnt = s.tx_cnt - CNT_ONE;
          if (pop_from_full && s.writable && s.ra[REG_INT][1]) s.tx_pending = 1'b1;
          s = int_check(s);
        end
      end
      MODE_CONNECT: begin
        if (s.connected != in_r.flag_value) begin
          s.cur = CAUSE_NONE;
          s.last = CAUSE_NONE;
          s.rr = CAUSE_NONE;
          s.handler = HND_NONE;
          s.connected = in_r.flag_value;
          s.writable = in_r.flag_value;
          s = host_reset(s);
        end
      end
      MODE_WRITABLE: begin
        nflag = s.connected && in_r.flag_value;
        if (s.writable != nflag) begin
          s.writable = nflag;
          if (!nflag) s.tx_pending = 1'b0;
          else if (s.ra[REG_INT][1] && s.tx_cnt < CNT_FULL) s.tx_pending = 1'b1;
          s = int_check(s);
        end
      end
      MODE_ACK: begin
        if (s.handler == HND_MOUSE) begin
          s.handler = HND_NONE;
          if (!r9[1]) begin
            if (r9[0])
              out_nxt.ack_vector = r9[4] ? (s.vbase & 8'h8f) + 8'h20 :
                                           (s.vbase & 8'hf1) + 8'd4;
            else
              out_nxt.ack_vector = s.vbase;
            out_nxt.ack_valid = 1'b1;
            s.mouse_acked = 1'b1;
          end
          s = serial_check(s);
        end else if (s.handler == HND_SERIAL) begin
          c = s.cur;
          s.handler = HND_NONE;
          s.cur = CAUSE_NONE;
          if (c == CAUSE_NONE || !cause_pending(s, c)) begin
            // cause went away: null vector, or the base vector when wr9 bit 0 is clear
            s = int_check(s);
            if (!r9[1]) begin
              out_nxt.ack_vector = r9[0] ? null_vector(s) : s.vbase;
              out_nxt.ack_valid = 1'b1;
            end
          end else begin
            s.last = c;
            s.rr = c;
            if (c == CAUSE_TX) s.tx_pending = 1'b0;
            if (!r9[1]) begin
              out_nxt.ack_vector = r9[0] ? vector_for(s, c) : s.vbase;
              out_nxt.ack_valid = 1'b1;
            end
            s = int_check(s);
          end
        end
      end
      default: ;
    endcase

    out_nxt.irq_request = s.handler != HND_NONE;
    out_nxt.irq_source = s.handler;
    out_nxt.tx_fill = s.connected ? 13'(s.tx_cnt) : 13'd0;
  end

  scc_fifo u_rx_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (proc ? s.rx_cmd : '0),
    .wdata     (in_r.write_data),
    .head_data (rx_head)
  );

  scc_fifo u_tx_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (proc ? s.tx_cmd : '0),
    .wdata     (in_r.write_data),
    .head_data (tx_head)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
      state_r <= '0;
    end else begin
      if (in_valid && !in_stall) in_vld_r <= 1'b1;
      else if (proc) in_vld_r <= 1'b0;
      if (proc) out_vld_r <= 1'b1;
      else if (!out_stall) out_vld_r <= 1'b0;
      if (proc) state_r <= s;
    end
    if (in_valid && !in_stall) in_r <= in_data;
    if (proc) out_r <= out_nxt;
    // mouse packet sampled from the item that raised wr5 bit 1
    if (proc && s.pkt_load) begin
      pkt_r[2] <= in_r.mouse_buttons;
      pkt_r[1] <= in_r.mouse_dx;
      pkt_r[0] <= in_r.mouse_dy;
    end
  end

endmodule

`default_nettype wire

@@ hdl/scc_ram.sv @@
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module scc_ram #(
  parameter int W = 8,
  parameter int D = 4096,
  localparam int AW = $clog2(D)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [W-1:0]  wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [W-1:0]  rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ hdl/scc_fifo.sv @@
// byte fifo: head and tail pointers around one scc_ram, head byte always presented
// depends on scc_pkg and scc_ram; occupancy is kept by the caller
`default_nettype none

module scc_fifo
  import scc_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire scc_fifo_cmd_t cmd,
  input  wire logic [7:0]    wdata,
  output logic      [7:0]    head_data
);

  localparam logic [ADDR_W-1:0] LAST = ADDR_W'(FIFO_DEPTH - 1);

  logic [ADDR_W-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [7:0]        rdata, byp_data_r;
  logic              byp_r;

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    if (cmd.clr) begin
      head_nxt = '0;
      tail_nxt = '0;
    end else begin
      if (cmd.pop) head_nxt = (head_r == LAST) ? '0 : head_r + 1'b1;
      if (cmd.push) tail_nxt = (tail_r == LAST) ? '0 : tail_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      byp_r <= 1'b0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      // write landing on the slot being read this cycle
      byp_r <= cmd.push && (tail_r == head_nxt);
    end
    byp_data_r <= wdata;
  end

  scc_ram #(.W(8), .D(FIFO_DEPTH)) u_ram (
    .clk   (clk),
    .we    (cmd.push),
    .waddr (tail_r),
    .wdata (wdata),
    .raddr (head_nxt),
    .rdata (rdata)
  );

  assign head_data = byp_r ? byp_data_r : rdata;

endmodule

`default_nettype wire
